/* hdl/kps_pkg.sv */
// kps_pkg: shared types and constants for the matrix keypad scanner
// no dependencies; imported by every module of the block
package kps_pkg;

  localparam int unsigned MAP_DEPTH  = 64;
  localparam int unsigned MAP_AW     = $clog2(MAP_DEPTH);
  localparam int unsigned BM_W       = 32;
  localparam int unsigned COL_W      = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  // scan column code for the phase with every column high
  localparam logic [COL_W-1:0] ALL_HIGH_PHASE = 4'd8;
  localparam logic [7:0]       SPACE_CHAR     = 8'h20;
  localparam logic [7:0]       ALL_HIGH_DRIVE = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE = 1'b0,
    REG_SETTLE = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KEY_NONE   = 2'd0,
    KEY_SINGLE = 2'd1,
    KEY_MANY   = 2'd2
  } key_status_t;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  // result of one beat out of the scan stage
  typedef struct packed {
    logic [7:0]        drive;
    logic              done;
    logic              changed;
    logic [BM_W-1:0]   bitmap;
    key_status_t       status;
    logic [MAP_AW-1:0] char_addr;
  } scan_res_t;

endpackage

/* hdl/matrix_keypad_scanner.sv */
// matrix keypad scanner: tick-driven 8x8 column scan with keymap decode
// pipeline: an accepted input beat is registered in stage b, then in the output register
// throughput: one beat per cycle while the output register is not stalled
// reset: sequencer returns to the all-high phase, bitmaps clear, the keymap
// reads as spaces at once through per-entry written flags (no clearing pass)
module matrix_keypad_scanner import kps_pkg::*; #(
  parameter int unsigned ROWS        = 8,
  parameter int unsigned COLS        = 8,
  parameter int unsigned BITMAP_KEYS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  req_type,
  input  logic [7:0]            row_lines,
  input  logic [5:0]            map_index,
  input  logic [7:0]            map_char,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            col_drive,
  output logic                  scan_done,
  output logic [31:0]           key_bitmap,
  output logic [1:0]            key_status,
  output logic [7:0]            pressed_char,
  output logic                  bitmap_changed
);

  logic      accept;
  logic      b_valid;
  logic      b_move;
  scan_res_t res;
  scan_res_t b_res;
  logic [7:0] km_data;
  logic [7:0] b_char;

  // handshake: stage b moves on when the output register is free or taken
  assign b_move   = b_valid && (!out_valid || !out_stall);
  assign in_stall = b_valid && !b_move;
  assign accept   = in_valid && !in_stall;

  kps_scan #(
    .ROWS        (ROWS),
    .COLS        (COLS),
    .BITMAP_KEYS (BITMAP_KEYS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (accept),
    .req_type  (req_type),
    .row_lines (row_lines),
    .res       (res)
  );

  kps_keymap u_keymap (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && (req_type == REQ_LOAD)),
    .wr_addr (map_index),
    .wr_data (map_char),
    .rd_en   (accept),
    .rd_addr (res.char_addr),
    .rd_data (km_data)
  );

  // stage b: scan result waiting on the keymap read
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_move) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_res <= res;
    end
  end

  assign b_char = (b_res.status == KEY_SINGLE) ? km_data : 8'd0;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      col_drive      <= b_res.drive;
      scan_done      <= b_res.done;
      key_bitmap     <= b_res.bitmap;
      key_status     <= b_res.status;
      pressed_char   <= b_char;
      bitmap_changed <= b_res.changed;
    end
  end

endmodule

/* hdl/kps_keymap.sv */
// kps_keymap: 64-entry keymap memory, one write and one registered read port
// depends on kps_pkg; unwritten entries read as space via per-entry valid bits
module kps_keymap import kps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [MAP_AW-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [MAP_AW-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0]           mem [MAP_DEPTH];
  logic [MAP_DEPTH-1:0] written;
  logic [7:0]           rd_raw;
  logic                 rd_written;
  logic                 fwd_hit;
  logic [7:0]           fwd_data;

  // memory array, write then registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // written flags, cleared by reset so the map starts as spaces
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // read-during-write forwarding and flag capture
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit    <= 1'b0;
      rd_written <= 1'b0;
    end else if (rd_en) begin
      fwd_hit    <= wr_en && (wr_addr == rd_addr);
      rd_written <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr_data;
    end
  end

  // read data select
  assign rd_data = fwd_hit ? fwd_data : (rd_written ? rd_raw : SPACE_CHAR);

endmodule

/* hdl/kps_scan.sv */
// kps_scan: configuration registers, column sequencer and bitmap build/publish
// depends on kps_pkg; hands a scan_res_t to the top level each accepted beat
module kps_scan import kps_pkg::*; #(
  parameter int unsigned ROWS        = 8,
  parameter int unsigned COLS        = 8,
  parameter int unsigned BITMAP_KEYS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  step,
  input  logic                  req_type,
  input  logic [7:0]            row_lines,
  output scan_res_t             res
);

  logic             enable;
  logic [7:0]       settle_ticks;
  logic [COL_W-1:0] scan_column, scan_column_next;
  logic [7:0]       settle_count, settle_count_next;
  logic [BM_W-1:0]  partial_bitmap, partial_bitmap_next;
  logic [BM_W-1:0]  published_bitmap, published_bitmap_next;

  logic [7:0]       need;
  logic [8:0]       cnt_inc;
  logic [4:0]       col_inc;
  logic [BM_W-1:0]  sampled;
  logic             done;
  logic             changed;
  logic [BM_W-1:0]  bm;
  logic [BM_W-1:0]  bm_dec;
  logic [MAP_AW-1:0] addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b0;
      settle_ticks <= 8'd2;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ENABLE: enable       <= cfg_data[0];
        REG_SETTLE: settle_ticks <= cfg_data[7:0];
        default:    ;
      endcase
    end
  end

  // row sample merged into the partial bitmap
  always_comb begin
    int idx;
    sampled = partial_bitmap;
    for (int r = 0; r < 8; r++) begin
      idx = r * int'(COLS) + int'(scan_column);
      if (r < int'(ROWS) && !row_lines[r] && idx < int'(BITMAP_KEYS) && idx < int'(BM_W))
        sampled[idx[4:0]] = 1'b1;
    end
  end

  assign need    = (settle_ticks == 8'd0) ? 8'd1 : settle_ticks;
  assign cnt_inc = {1'b0, settle_count} + 9'd1;
  assign col_inc = {1'b0, scan_column} + 5'd1;

  // sequencer next state
  always_comb begin
    scan_column_next      = scan_column;
    settle_count_next     = settle_count;
    partial_bitmap_next   = partial_bitmap;
    published_bitmap_next = published_bitmap;
    done                  = 1'b0;
    changed               = 1'b0;
    if (req_type == REQ_TICK) begin
      if (!enable) begin
        scan_column_next    = ALL_HIGH_PHASE;
        settle_count_next   = 8'd0;
        partial_bitmap_next = '0;
      end else if (cnt_inc >= {1'b0, need}) begin
        settle_count_next = 8'd0;
        if (scan_column >= COL_W'(COLS)) begin
          scan_column_next    = '0;
          partial_bitmap_next = '0;
        end else if (col_inc >= 5'(COLS)) begin
          changed               = (sampled != published_bitmap);
          published_bitmap_next = sampled;
          partial_bitmap_next   = '0;
          scan_column_next      = ALL_HIGH_PHASE;
          done                  = 1'b1;
        end else begin
          partial_bitmap_next = sampled;
          scan_column_next    = col_inc[COL_W-1:0];
        end
      end else begin
        settle_count_next = cnt_inc[7:0];
      end
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_column      <= ALL_HIGH_PHASE;
      settle_count     <= 8'd0;
      partial_bitmap   <= '0;
      published_bitmap <= '0;
    end else if (step) begin
      scan_column      <= scan_column_next;
      settle_count     <= settle_count_next;
      partial_bitmap   <= partial_bitmap_next;
      published_bitmap <= published_bitmap_next;
    end
  end

  // decode of the bitmap shown with this beat
  assign bm     = enable ? published_bitmap_next : '0;
  assign bm_dec = bm & (bm - BM_W'(1));

  always_comb begin
    addr = '0;
    for (int i = 0; i < int'(BM_W); i++) begin
      if (bm[i])
        addr = addr | MAP_AW'(i);
    end
  end

  always_comb begin
    res.bitmap    = bm;
    res.char_addr = addr;
    res.done      = enable && done;
    res.changed   = enable && changed;
    if (!enable || scan_column >= COL_W'(COLS) || scan_column >= ALL_HIGH_PHASE)
      res.drive = ALL_HIGH_DRIVE;
    else
      res.drive = ~(8'd1 << scan_column[2:0]);
    if (bm == '0)
      res.status = KEY_NONE;
    else if (bm_dec == '0)
      res.status = KEY_SINGLE;
    else
      res.status = KEY_MANY;
  end

endmodule

/* hdl/kps_checker.sv */
// kps_checker: port-level checks of the keypad scanner result channel
// depends on kps_pkg; bound to matrix_keypad_scanner at the end of this file
module kps_checker import kps_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        scan_done,
  input logic [31:0] key_bitmap,
  input logic [1:0]  key_status,
  input logic [7:0]  pressed_char,
  input logic        bitmap_changed
);

  // a change flag only comes with a published scan
  a_changed_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && bitmap_changed |-> scan_done)
    else $error("bitmap_changed without scan_done");

  // no-key status goes with an empty bitmap and nothing else
  a_none_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((key_bitmap == 32'd0) == (key_status == KEY_NONE)))
    else $error("key_status disagrees with key_bitmap");

  // single status exactly when one bit is set
  a_single_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (($countones(key_bitmap) == 1) == (key_status == KEY_SINGLE)))
    else $error("single status mismatch");

  // character only for a single key
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_status != KEY_SINGLE |-> pressed_char == 8'd0)
    else $error("pressed_char set without a single key");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(key_bitmap) && $stable(pressed_char))
    else $error("stalled result beat changed");

endmodule

bind matrix_keypad_scanner kps_checker u_kps_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .scan_done      (scan_done),
  .key_bitmap     (key_bitmap),
  .key_status     (key_status),
  .pressed_char   (pressed_char),
  .bitmap_changed (bitmap_changed)
);
